>>> rtl/syllable_ngram_extractor_assert.svh
// assertion macros used by the checker file of the syllable n-gram extractor
// depends on nothing; take it in by `include
`ifndef SYLLABLE_NGRAM_EXTRACTOR_ASSERT_SVH
`define SYLLABLE_NGRAM_EXTRACTOR_ASSERT_SVH

// antecedent implies consequent in the next cycle, masked during reset
`define SNG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle, checked during reset too
`define SNG_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/sng_pkg.sv
// shared types, constants and codes of the syllable n-gram extractor
// depends on nothing
package sng_pkg;

    localparam int MAX_GRAM    = 8;
    localparam int IDX_W       = (MAX_GRAM > 1) ? $clog2(MAX_GRAM) : 1;
    localparam int FILL_W      = $clog2(MAX_GRAM + 1);
    localparam int GRAM_W      = 4;
    localparam int SIZE_W      = (FILL_W > GRAM_W) ? FILL_W : GRAM_W;
    localparam int QPTR_W      = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    localparam logic [GRAM_W-1:0] GRAM_RESET = GRAM_W'(2);
    localparam logic [7:0]        CHAR_SPACE = 8'h20;
    localparam logic [7:0]        CHAR_NL    = 8'h0a;

    typedef struct packed {
        logic       pair;
        logic [7:0] lead;
        logic [7:0] trail;
    } syllable_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEAD,
        ST_TRAIL
    } back_state_t;

endpackage

>>> rtl/syllable_ngram_extractor.sv
// top level of the syllable n-gram extractor
// depends on sng_pkg, sng_front, sng_queue, sng_back
//
// Input channel in_valid/in_ready/in_byte carries raw text bytes, one request
// per byte. Output channel out_valid/out_ready/out_byte/gram_last carries the
// bytes of each emitted n-gram, oldest syllable first, gram_last on the final
// byte. Config channel cfg_valid/cfg_ready/gram_size sets the n-gram size;
// cfg_ready is always high and the write takes effect at the next syllable.
// When the back end is free, a byte that completes a syllable is written into
// a queue slot and popped by the back end in its idle state, and its first
// byte then goes to the output register. The back end takes each syllable from
// the two-entry queue and emits up to twice the gram size bytes, and it takes
// no new syllable before the last byte of the gram is loaded. Lead bytes and
// dropped blanks are taken by the front end alone while the queue has room.
// When the receiver stalls, the output byte holds, the back end waits and the
// queue fills, after which in_ready drops. Reset empties the queue, clears the
// fill count and held lead byte, and sets the gram size to two.
module syllable_ngram_extractor
    import sng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GRAM_W-1:0] gram_size,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              gram_last
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    syllable_t q_in;
    syllable_t q_out;

    sng_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sng_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_out)
    );

    sng_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .gram_size (gram_size),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .gram_last (gram_last)
    );

endmodule

>>> rtl/sng_front.sv
// front end: accepts text bytes, pairs lead and trail bytes, drops blanks
// depends on sng_pkg
module sng_front
    import sng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] in_byte,
    input  logic      q_full,
    output logic      q_push,
    output syllable_t q_data
);

    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;
    logic       accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        q_push            = 1'b0;
        q_data            = '{pair: 1'b0, lead: 8'h00, trail: in_byte};
        if (accept)
        begin
            priority if (lead_pending_reg)
            begin
                // any byte completes a held lead, blanks included
                lead_pending_next = 1'b0;
                q_push            = 1'b1;
                q_data            = '{pair: 1'b1, lead: lead_byte_reg, trail: in_byte};
            end
            else if (in_byte[7])
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = in_byte;
            end
            else if (in_byte == CHAR_SPACE || in_byte == CHAR_NL)
            begin
                q_push = 1'b0;
            end
            else
            begin
                q_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_byte_reg    <= lead_byte_next;
        end
    end

endmodule

>>> rtl/sng_queue.sv
// short syllable queue between front and back end
// depends on sng_pkg
module sng_queue
    import sng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  syllable_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output syllable_t data
);

    syllable_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign data    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

>>> rtl/sng_back.sv
// back end: syllable window, gram size register and byte sequencer
// depends on sng_pkg
module sng_back
    import sng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [GRAM_W-1:0] gram_size,
    input  logic              q_valid,
    input  syllable_t         q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              gram_last
);

    syllable_t         window_reg [MAX_GRAM];
    logic [GRAM_W-1:0] gram_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_inc;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    back_state_t       state_reg;
    back_state_t       state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              gram_last_reg;
    logic              gram_last_next;
    logic              load;
    logic              load_ok;
    logic [SIZE_W-1:0] eff_size;
    logic [IDX_W-1:0]  start_idx;
    logic              window_full;
    syllable_t         entry;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign gram_last = gram_last_reg;

    // zero acts as one, oversize clamps to the window depth
    always_comb
    begin
        priority if (gram_reg == '0)
            eff_size = SIZE_W'(1);
        else if (SIZE_W'(gram_reg) > SIZE_W'(MAX_GRAM))
            eff_size = SIZE_W'(MAX_GRAM);
        else
            eff_size = SIZE_W'(gram_reg);
    end

    assign start_idx   = IDX_W'(eff_size - SIZE_W'(1));
    assign fill_inc    = (fill_reg == FILL_W'(MAX_GRAM)) ? fill_reg : fill_reg + 1'b1;
    assign window_full = (SIZE_W'(fill_inc) >= eff_size);
    assign entry       = window_reg[idx_reg];
    assign load_ok     = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && window_full)
                    state_next = ST_LEAD;
            end
            ST_LEAD:
            begin
                if (load_ok)
                begin
                    priority if (entry.pair)
                        state_next = ST_TRAIL;
                    else if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        state_next = ST_LEAD;
                end
            end
            ST_TRAIL:
            begin
                if (load_ok)
                    state_next = (idx_reg == '0) ? ST_IDLE : ST_LEAD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop          = 1'b0;
        load           = 1'b0;
        idx_next       = idx_reg;
        out_byte_next  = out_byte_reg;
        gram_last_next = gram_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    idx_next = start_idx;
                end
            end
            ST_LEAD:
            begin
                if (load_ok)
                begin
                    load = 1'b1;
                    if (entry.pair)
                    begin
                        out_byte_next  = entry.lead;
                        gram_last_next = 1'b0;
                    end
                    else
                    begin
                        out_byte_next  = entry.trail;
                        gram_last_next = (idx_reg == '0);
                        if (idx_reg != '0)
                            idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (load_ok)
                begin
                    load           = 1'b1;
                    out_byte_next  = entry.trail;
                    gram_last_next = (idx_reg == '0);
                    if (idx_reg != '0)
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gram_reg      <= GRAM_RESET;
            fill_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                gram_reg <= gram_size;
            if (q_pop)
                fill_reg <= fill_inc;
        end
    end

    // window entry 0 holds the newest syllable
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        gram_last_reg <= gram_last_next;
        if (q_pop)
        begin
            window_reg[0] <= q_data;
            for (int i = 1; i < MAX_GRAM; i++)
                window_reg[i] <= window_reg[i-1];
        end
    end

endmodule

>>> rtl/sng_checker.sv
// port-level checks of the syllable n-gram extractor, bound to the top level
// depends on sng_pkg and syllable_ngram_extractor_assert.svh
`include "syllable_ngram_extractor_assert.svh"

module sng_checker
    import sng_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [GRAM_W-1:0] gram_size,
    input logic              in_valid,
    input logic              in_ready,
    input logic [7:0]        in_byte,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        out_byte,
    input logic              gram_last
);

    // a stalled output request keeps its payload
    `SNG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(gram_last))

    // bytes of one gram follow each other without a gap
    `SNG_ASSERT_NEXT(a_gram_dense, clk, rst_n, out_valid && out_ready && !gram_last, out_valid)

    // a stalled input request keeps its byte
    `SNG_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_byte))

    // a stalled config request keeps its value
    `SNG_ASSERT_NEXT(a_cfg_hold, clk, rst_n, cfg_valid && !cfg_ready, cfg_valid && $stable(gram_size))

    // nothing comes out right after reset
    `SNG_ASSERT_NEXT_RAW(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind syllable_ngram_extractor sng_checker u_sng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .gram_size (gram_size),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .gram_last (gram_last)
);

>>> tb/tb_top.sv
// self-checking testbench for the syllable n-gram extractor
// keeps its own model of the syllable window and checks every output byte
// depends on sng_pkg and syllable_ngram_extractor
`timescale 1ns / 100ps

module tb_top;
    import sng_pkg::*;

    localparam int SETTLE_CYCLES   = 24;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 42;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } gram_byte_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GRAM_W-1:0] gram_size = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [7:0]        in_byte   = 8'h00;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        out_byte;
    logic              gram_last;

    // model of the block
    syllable_t         recent_syllables [MAX_GRAM];
    int unsigned       syllables_seen = 0;
    logic [7:0]        lead_held      = 8'h00;
    logic              lead_waiting   = 1'b0;
    logic [GRAM_W-1:0] size_setting   = GRAM_RESET;
    gram_byte_t        gram_bytes_due [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    syllable_ngram_extractor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .gram_size (gram_size),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .gram_last (gram_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < MAX_GRAM; i++)
            recent_syllables[i] = '0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] expected,
                                   input logic [7:0] actual);
        $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what,
                 expected, actual);
        mismatches++;
    endtask

    function automatic void push_syllable(input syllable_t s);
        for (int i = MAX_GRAM - 1; i > 0; i--)
            recent_syllables[i] = recent_syllables[i - 1];
        recent_syllables[0] = s;
        if (syllables_seen < MAX_GRAM)
            syllables_seen++;
    endfunction

    // works out the n-gram bytes one accepted text byte causes
    function automatic void predict_gram(input logic [7:0] b);
        syllable_t   s;
        int unsigned span;
        if (lead_waiting)
        begin
            lead_waiting = 1'b0;
            s = '{pair: 1'b1, lead: lead_held, trail: b};
        end
        else if (b[7])
        begin
            lead_held    = b;
            lead_waiting = 1'b1;
            return;
        end
        else if (b == CHAR_SPACE || b == CHAR_NL)
            return;
        else
            s = '{pair: 1'b0, lead: 8'h00, trail: b};
        push_syllable(s);

        if (size_setting == 0)
            span = 1;
        else if (size_setting > MAX_GRAM)
            span = MAX_GRAM;
        else
            span = size_setting;
        if (syllables_seen < span)
            return;

        for (int i = span - 1; i >= 0; i--)
        begin
            if (recent_syllables[i].pair)
                gram_bytes_due.push_back('{data: recent_syllables[i].lead, last: 1'b0});
            gram_bytes_due.push_back('{data: recent_syllables[i].trail, last: 1'b0});
        end
        gram_bytes_due[gram_bytes_due.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin : check_results
        gram_byte_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (gram_bytes_due.size() == 0)
                report_mismatch("unexpected out_byte", 8'h00, out_byte);
            else
            begin
                due = gram_bytes_due.pop_front();
                if (out_byte !== due.data)
                    report_mismatch("out_byte", due.data, out_byte);
                if (gram_last !== due.last)
                    report_mismatch("gram_last", 8'(due.last), 8'(gram_last));
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // ends the run when no channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL syllable_ngram_extractor");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_gram(b);
        @(negedge clk);
    endtask

    // lets lead bytes and blanks still in flight clear the front end too
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (gram_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gram_size(input logic [GRAM_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        gram_size <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        size_setting = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly words of plain and two-byte syllables between blanks, some noise
    task automatic send_text(input int syllable_count);
        int         sent;
        int         pick;
        logic [7:0] b;
        sent = 0;
        while (sent < syllable_count)
        begin
            if ($urandom_range(99) < 3)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                b = 8'($urandom_range(127));
                if (b == CHAR_SPACE || b == CHAR_NL)
                    b = 8'h61;
                send_byte(b);
                sent++;
            end
            else if (pick < 75)
            begin
                send_byte(8'($urandom_range(255, 128)));
                if ($urandom_range(9) == 0)
                    b = $urandom_range(1) ? CHAR_SPACE : CHAR_NL;
                else
                    b = 8'($urandom_range(255));
                send_byte(b);
                sent++;
            end
            else if (pick < 88)
                send_byte($urandom_range(1) ? CHAR_SPACE : CHAR_NL);
            else
            begin
                // a stray lead byte here takes the next byte as its trail
                b = 8'($urandom_range(255));
                send_byte(b);
                if (!b[7] && b != CHAR_SPACE && b != CHAR_NL)
                    sent++;
            end
        end
    endtask

    // default size two: blanks, pairs with blank and high trails, byte extremes
    task automatic test_blanks_and_pairs();
        send_idle_pct = 15;
        recv_idle_pct = 50;
        send_byte(8'h61);
        send_byte(CHAR_SPACE);
        send_byte(8'h62);
        send_byte(CHAR_NL);
        send_byte(8'hc3);
        send_byte(8'ha9);
        send_byte(8'h80);
        send_byte(CHAR_SPACE);
        send_byte(8'hff);
        send_byte(CHAR_NL);
        send_byte(8'h00);
        send_byte(8'h7f);
    endtask

    // size one, zero, eight, above eight, changed with the window already full
    task automatic test_size_limits();
        write_gram_size(4'd1);
        send_byte(8'h78);
        write_gram_size(4'd0);
        send_byte(8'hff);
        send_byte(8'h80);
        write_gram_size(4'd8);
        send_byte(8'h71);
        write_gram_size(4'd15);
        send_byte(8'h7a);
        write_gram_size(4'd9);
        send_byte(8'h81);
        send_byte(8'h41);
    endtask

    // every window slot a pair gives the longest n-gram
    task automatic test_longest_gram();
        write_gram_size(4'd8);
        for (int i = 0; i < 8; i++)
        begin
            send_byte(8'($urandom_range(255, 128)));
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic test_random_text();
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct = 50;
                    write_gram_size(GRAM_W'($urandom_range(3, 1)));
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 15;
                    write_gram_size(4'd8);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_gram_size(GRAM_W'($urandom_range(15)));
                end
            endcase
            send_text(ITEMS_PER_PHASE / 2);
            write_gram_size(GRAM_W'($urandom_range(15)));
            send_text(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
        end
    endtask

    // a lead byte with no trail at the end stays held and gives nothing
    task automatic test_held_lead_at_end();
        send_byte(8'hd5);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_blanks_and_pairs();
        test_size_limits();
        test_longest_gram();
        test_random_text();
        test_held_lead_at_end();
        wait_drained();
        if (mismatches == 0)
            $display("PASS syllable_ngram_extractor");
        else
            $display("FAIL syllable_ngram_extractor");
        $finish;
    end

endmodule
